@@ hw/rtl/lps_pkg.sv @@
// Shared types and constants for the line pixel stepper.
// Depends on nothing; every other file of the block but lps_out_queue imports it.
package lps_pkg;

    localparam int COORD_BITS_DEF = 12;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_STEP = 1'b1;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'b0001,
        PH_FIRST  = 4'b0010,
        PH_SECOND = 4'b0100,
        PH_WALK   = 4'b1000
    } phase_t;

    typedef enum logic [3:0] {
        MODE_Y       = 4'b0001,
        MODE_X       = 4'b0010,
        MODE_SHALLOW = 4'b0100,
        MODE_STEEP   = 4'b1000
    } walk_mode_t;

endpackage

@@ hw/rtl/lps_req_if.sv @@
// Request channel of the line pixel stepper: valid, ready and one request beat.
// Depends on lps_pkg for the default coordinate width.
interface lps_req_if
    import lps_pkg::*;
#(
    parameter int W = COORD_BITS_DEF
);
    logic                valid;
    logic                ready;
    logic                kind;
    logic signed [W-1:0] x_start;
    logic signed [W-1:0] y_start;
    logic signed [W-1:0] x_end;
    logic signed [W-1:0] y_end;

    modport source (output valid, kind, x_start, y_start, x_end, y_end, input ready);
    modport sink   (input valid, kind, x_start, y_start, x_end, y_end, output ready);
endinterface

@@ hw/rtl/lps_rsp_if.sv @@
// Result channel of the line pixel stepper: valid, ready and one pixel beat.
// Depends on lps_pkg for the default coordinate width.
interface lps_rsp_if
    import lps_pkg::*;
#(
    parameter int W = COORD_BITS_DEF
);
    logic                valid;
    logic                ready;
    logic                pixel_valid;
    logic signed [W-1:0] pixel_x;
    logic signed [W-1:0] pixel_y;
    logic                last;

    modport source (output valid, pixel_valid, pixel_x, pixel_y, last, input ready);
    modport sink   (input valid, pixel_valid, pixel_x, pixel_y, last, output ready);
endinterface

@@ hw/rtl/lps_step_core.sv @@
// Line state registers and the step logic that turns a request into a result beat.
// Depends on lps_pkg for the phase and walk mode types.
module lps_step_core
    import lps_pkg::*;
#(
    parameter int W = COORD_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  logic                kind,
    input  logic signed [W-1:0] x_start,
    input  logic signed [W-1:0] y_start,
    input  logic signed [W-1:0] x_end,
    input  logic signed [W-1:0] y_end,
    output logic                res_pixel_valid,
    output logic signed [W-1:0] res_x,
    output logic signed [W-1:0] res_y,
    output logic                res_last
);

    localparam int DW = W + 1;
    localparam int TW = W + 2;
    localparam int EW = W + 3;
    localparam logic signed [W-1:0] C_ONE = W'(1);

    phase_t               phase_reg, phase_next;
    walk_mode_t           mode_reg, mode_next;
    logic signed [W-1:0]  cur_x_reg, cur_x_next;
    logic signed [W-1:0]  cur_y_reg, cur_y_next;
    logic signed [W-1:0]  far_x_reg, far_x_next;
    logic signed [W-1:0]  far_y_reg, far_y_next;
    logic signed [W-1:0]  stop_reg, stop_next;
    logic signed [EW-1:0] err_reg, err_next;
    logic signed [TW-1:0] run_reg, run_next;
    logic signed [TW-1:0] rise_reg, rise_next;

    logic signed [DW-1:0] dx, dy, dxa, dys, dya;
    logic signed [TW-1:0] rise_abs;
    logic                 rise_pos;
    logic signed [W-1:0]  step_y, nxt_x, nxt_y;
    logic signed [EW-1:0] err_a, err_b;

    always_comb
    begin
        dx       = DW'(far_x_reg) - DW'(cur_x_reg);
        dy       = DW'(far_y_reg) - DW'(cur_y_reg);
        dxa      = (dx < 0) ? -dx : dx;
        dys      = (dx < 0) ? -dy : dy;
        dya      = (dys < 0) ? -dys : dys;
        rise_pos = (rise_reg > 0);
        rise_abs = (rise_reg < 0) ? -rise_reg : rise_reg;
        step_y   = rise_pos ? C_ONE : -C_ONE;
        nxt_x    = cur_x_reg + C_ONE;
        nxt_y    = cur_y_reg + step_y;
        err_a    = err_reg - EW'(rise_abs);
        err_b    = rise_pos ? (err_reg - EW'(run_reg)) : (err_reg + EW'(run_reg));

        phase_next      = phase_reg;
        mode_next       = mode_reg;
        cur_x_next      = cur_x_reg;
        cur_y_next      = cur_y_reg;
        far_x_next      = far_x_reg;
        far_y_next      = far_y_reg;
        stop_next       = stop_reg;
        err_next        = err_reg;
        run_next        = run_reg;
        rise_next       = rise_reg;
        res_pixel_valid = 1'b0;
        res_x           = '0;
        res_y           = '0;
        res_last        = 1'b0;

        if (kind == KIND_LOAD)
        begin
            cur_x_next = x_start;
            cur_y_next = y_start;
            far_x_next = x_end;
            far_y_next = y_end;
            phase_next = PH_FIRST;
        end
        else
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    phase_next = PH_IDLE;
                end
                PH_FIRST:
                begin
                    res_pixel_valid = 1'b1;
                    res_x           = cur_x_reg;
                    res_y           = cur_y_reg;
                    phase_next      = PH_SECOND;
                end
                PH_SECOND:
                begin
                    res_pixel_valid = 1'b1;
                    res_x           = far_x_reg;
                    res_y           = far_y_reg;
                    phase_next      = PH_WALK;
                    if (dx == 0)
                    begin
                        mode_next  = MODE_Y;
                        stop_next  = (cur_y_reg > far_y_reg) ? cur_y_reg : far_y_reg;
                        cur_y_next = (cur_y_reg < far_y_reg) ? cur_y_reg : far_y_reg;
                    end
                    else if (dy == 0)
                    begin
                        mode_next  = MODE_X;
                        stop_next  = (cur_x_reg > far_x_reg) ? cur_x_reg : far_x_reg;
                        cur_x_next = (cur_x_reg < far_x_reg) ? cur_x_reg : far_x_reg;
                    end
                    else
                    begin
                        if (dx < 0)
                        begin
                            cur_x_next = far_x_reg;
                            cur_y_next = far_y_reg;
                            far_x_next = cur_x_reg;
                            far_y_next = cur_y_reg;
                        end
                        run_next  = TW'(dxa) + TW'(dxa);
                        rise_next = TW'(dys) + TW'(dys);
                        if (dxa >= dya)
                        begin
                            mode_next = MODE_SHALLOW;
                            err_next  = EW'(dxa);
                        end
                        else
                        begin
                            mode_next = MODE_STEEP;
                            err_next  = EW'(dys);
                        end
                    end
                end
                PH_WALK:
                begin
                    res_pixel_valid = 1'b1;
                    res_x           = cur_x_reg;
                    res_y           = cur_y_reg;
                    case (mode_reg)
                        MODE_Y:
                        begin
                            if (cur_y_reg >= stop_reg)
                                res_last = 1'b1;
                            else
                                cur_y_next = cur_y_reg + C_ONE;
                        end
                        MODE_X:
                        begin
                            if (cur_x_reg >= stop_reg)
                                res_last = 1'b1;
                            else
                                cur_x_next = nxt_x;
                        end
                        MODE_SHALLOW:
                        begin
                            cur_x_next = nxt_x;
                            if (nxt_x == far_x_reg)
                            begin
                                res_last = 1'b1;
                            end
                            else if (err_a < 0)
                            begin
                                cur_y_next = nxt_y;
                                err_next   = err_a + EW'(run_reg);
                            end
                            else
                            begin
                                err_next = err_a;
                            end
                        end
                        default:
                        begin
                            cur_y_next = nxt_y;
                            if (nxt_y == far_y_reg)
                            begin
                                res_last = 1'b1;
                            end
                            else if ((err_b < 0 && rise_pos) || (err_b > 0 && !rise_pos))
                            begin
                                cur_x_next = nxt_x;
                                err_next   = err_b + EW'(rise_reg);
                            end
                            else
                            begin
                                err_next = err_b;
                            end
                        end
                    endcase
                    if (res_last)
                        phase_next = PH_IDLE;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            mode_reg  <= MODE_Y;
            cur_x_reg <= '0;
            cur_y_reg <= '0;
            far_x_reg <= '0;
            far_y_reg <= '0;
            stop_reg  <= '0;
            err_reg   <= '0;
            run_reg   <= '0;
            rise_reg  <= '0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            mode_reg  <= mode_next;
            cur_x_reg <= cur_x_next;
            cur_y_reg <= cur_y_next;
            far_x_reg <= far_x_next;
            far_y_reg <= far_y_next;
            stop_reg  <= stop_next;
            err_reg   <= err_next;
            run_reg   <= run_next;
            rise_reg  <= rise_next;
        end
    end

endmodule

@@ hw/rtl/lps_out_queue.sv @@
// Two-entry result queue that registers each pixel beat and decouples the two channels.
// Depends on nothing outside this file.
module lps_out_queue #(
    parameter int DATA_BITS = 26
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  logic [DATA_BITS-1:0] push_data,
    input  logic                 pop_ready,
    output logic                 full,
    output logic                 out_valid,
    output logic [DATA_BITS-1:0] out_data
);

    logic [DATA_BITS-1:0] mem [2];
    logic                 wr_ptr_reg, wr_ptr_next;
    logic                 rd_ptr_reg, rd_ptr_next;
    logic [1:0]           count_reg, count_next;
    logic                 pop;

    assign full      = (count_reg == 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = mem[rd_ptr_reg];
    assign pop       = out_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ hw/rtl/line_pixel_stepper.sv @@
// Top level of the line pixel stepper: request register, step core and result queue.
// Depends on lps_pkg, lps_req_if, lps_rsp_if, lps_step_core and lps_out_queue.
//
// A load beat takes two endpoints and returns a beat without a pixel; each following
// step beat returns one pixel, first the first endpoint, then the second, then the walk,
// with last set on the final pixel, and later step beats return none. Every request beat
// yields exactly one result beat. The block takes one request per clock and returns one
// result per clock while the sink does not stall; a result is registered first in the
// request register and then in the result queue, and a full queue holds it in between.
// The step core updates the point and the error term for each request. The two-entry
// result queue lets one more request in while a result waits on a stalled sink.
module line_pixel_stepper
    import lps_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    lps_req_if.sink  req,
    lps_rsp_if.source rsp
);

    localparam int W  = COORD_BITS;
    localparam int QW = 2 * W + 2;

    logic                s1_valid_reg;
    logic                s1_kind_reg;
    logic signed [W-1:0] s1_xs_reg, s1_ys_reg, s1_xe_reg, s1_ye_reg;
    logic                q_full;
    logic                fire;
    logic                req_take;

    logic                res_pixel_valid, res_last;
    logic signed [W-1:0] res_x, res_y;
    logic [QW-1:0]       q_out;

    assign fire      = s1_valid_reg && !q_full;
    assign req.ready = !s1_valid_reg || !q_full;
    assign req_take  = req.valid && req.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (req.ready)
            s1_valid_reg <= req.valid;
    end

    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            s1_kind_reg <= req.kind;
            s1_xs_reg   <= req.x_start;
            s1_ys_reg   <= req.y_start;
            s1_xe_reg   <= req.x_end;
            s1_ye_reg   <= req.y_end;
        end
    end

    lps_step_core #(
        .W (W)
    ) u_core (
        .clk             (clk),
        .rst_n           (rst_n),
        .fire            (fire),
        .kind            (s1_kind_reg),
        .x_start         (s1_xs_reg),
        .y_start         (s1_ys_reg),
        .x_end           (s1_xe_reg),
        .y_end           (s1_ye_reg),
        .res_pixel_valid (res_pixel_valid),
        .res_x           (res_x),
        .res_y           (res_y),
        .res_last        (res_last)
    );

    lps_out_queue #(
        .DATA_BITS (QW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fire),
        .push_data ({res_pixel_valid, res_last, res_x, res_y}),
        .pop_ready (rsp.ready),
        .full      (q_full),
        .out_valid (rsp.valid),
        .out_data  (q_out)
    );

    assign rsp.pixel_valid = q_out[QW-1];
    assign rsp.last        = q_out[QW-2];
    assign rsp.pixel_x     = q_out[2*W-1:W];
    assign rsp.pixel_y     = q_out[W-1:0];

endmodule

@@ hw/rtl/lps_checker.sv @@
// Port-level assertions for the line pixel stepper and the bind that attaches them.
// Depends on lps_pkg, line_pixel_stepper and its channel interfaces.
module lps_checker
    import lps_pkg::*;
#(
    parameter int W = COORD_BITS_DEF
)
(
    input logic                clk,
    input logic                rst_n,
    input logic                rsp_valid,
    input logic                rsp_ready,
    input logic                rsp_pixel_valid,
    input logic                rsp_last,
    input logic signed [W-1:0] rsp_pixel_x,
    input logic signed [W-1:0] rsp_pixel_y
);

    // A stalled result beat stays offered with the same contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pixel_valid) &&
            $stable(rsp_last) && $stable(rsp_pixel_x) && $stable(rsp_pixel_y))
        else $error("result beat changed while stalled");

    // The end of a line is always a real pixel.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_last |-> rsp_pixel_valid)
        else $error("last flag on a beat without a pixel");

    // A beat without a pixel carries all-zero fields.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_pixel_valid |-> rsp_pixel_x == 0 && rsp_pixel_y == 0 && !rsp_last)
        else $error("empty result beat with nonzero fields");

endmodule

bind line_pixel_stepper lps_checker #(
    .W (COORD_BITS)
) u_lps_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_pixel_valid (rsp.pixel_valid),
    .rsp_last        (rsp.last),
    .rsp_pixel_x     (rsp.pixel_x),
    .rsp_pixel_y     (rsp.pixel_y)
);

@@ bench/line_pixel_stepper_test.sv @@
// Self-checking bench for line_pixel_stepper: directed and random lines with random idling.
// Depends on lps_pkg, lps_req_if, lps_rsp_if and the line_pixel_stepper RTL.
// A built-in line walker predicts every pixel beat, and a sink process checks each one.
module line_pixel_stepper_test;
    import lps_pkg::*;

    localparam int CW = COORD_BITS_DEF;
    localparam int RANDOM_BEATS = 1000;
    localparam int QUIET_LIMIT = 1000;
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        logic          kind;
        logic [CW-1:0] xs;
        logic [CW-1:0] ys;
        logic [CW-1:0] xe;
        logic [CW-1:0] ye;
    } line_req_t;

    typedef struct packed {
        logic          pixel_valid;
        logic [CW-1:0] px;
        logic [CW-1:0] py;
        logic          last;
    } pixel_t;

    logic clk = 1'b0;
    logic rst_n;

    lps_req_if #(.W(CW)) req_ch ();
    lps_rsp_if #(.W(CW)) rsp_ch ();

    line_pixel_stepper #(.COORD_BITS(CW)) dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #4 clk = ~clk;

    phase_t     line_phase;
    walk_mode_t line_mode;
    int         pt_x;
    int         pt_y;
    int         far_x;
    int         far_y;
    int         axis_stop;
    int         err_acc;
    int         run2;
    int         rise2;

    pixel_t pixel_expect[$];
    bit     steady;
    int     beats_sent;
    int     lines_drawn;
    int     pixels_checked;
    int     mismatches;
    int     quiet_cycles;

    function automatic pixel_t next_pixel(line_req_t r);
        pixel_t p;
        int     dx;
        int     dy;
        int     tx;
        int     ty;
        int     e;
        int     run;
        int     rise;
        int     nx;
        int     ny;
        p = '0;
        if (r.kind == KIND_LOAD)
        begin
            pt_x = int'($signed(r.xs));
            pt_y = int'($signed(r.ys));
            far_x = int'($signed(r.xe));
            far_y = int'($signed(r.ye));
            line_phase = PH_FIRST;
        end
        else
        begin
            case (line_phase)
                PH_FIRST:
                begin
                    p.pixel_valid = 1'b1;
                    p.px = CW'(pt_x);
                    p.py = CW'(pt_y);
                    line_phase = PH_SECOND;
                end
                PH_SECOND:
                begin
                    p.pixel_valid = 1'b1;
                    p.px = CW'(far_x);
                    p.py = CW'(far_y);
                    dx = far_x - pt_x;
                    dy = far_y - pt_y;
                    if (dx == 0)
                    begin
                        line_mode = MODE_Y;
                        axis_stop = (pt_y > far_y) ? pt_y : far_y;
                        pt_y = (pt_y < far_y) ? pt_y : far_y;
                    end
                    else if (dy == 0)
                    begin
                        line_mode = MODE_X;
                        axis_stop = (pt_x > far_x) ? pt_x : far_x;
                        pt_x = (pt_x < far_x) ? pt_x : far_x;
                    end
                    else
                    begin
                        if (dx < 0)
                        begin
                            tx = pt_x;
                            ty = pt_y;
                            pt_x = far_x;
                            pt_y = far_y;
                            far_x = tx;
                            far_y = ty;
                            dx = -dx;
                            dy = -dy;
                        end
                        run2 = 2 * dx;
                        rise2 = 2 * dy;
                        if (dx >= ((dy < 0) ? -dy : dy))
                        begin
                            line_mode = MODE_SHALLOW;
                            err_acc = dx;
                        end
                        else
                        begin
                            line_mode = MODE_STEEP;
                            err_acc = dy;
                        end
                    end
                    line_phase = PH_WALK;
                end
                PH_WALK:
                begin
                    p.pixel_valid = 1'b1;
                    p.px = CW'(pt_x);
                    p.py = CW'(pt_y);
                    e = err_acc;
                    run = run2;
                    rise = rise2;
                    case (line_mode)
                        MODE_Y:
                        begin
                            if (pt_y >= axis_stop)
                                p.last = 1'b1;
                            else
                                pt_y = pt_y + 1;
                        end
                        MODE_X:
                        begin
                            if (pt_x >= axis_stop)
                                p.last = 1'b1;
                            else
                                pt_x = pt_x + 1;
                        end
                        MODE_SHALLOW:
                        begin
                            nx = pt_x + 1;
                            if (nx == far_x)
                                p.last = 1'b1;
                            else
                            begin
                                e = e - ((rise < 0) ? -rise : rise);
                                if (e < 0)
                                begin
                                    pt_y = pt_y + ((rise > 0) ? 1 : -1);
                                    e = e + run;
                                end
                            end
                            pt_x = nx;
                        end
                        default:
                        begin
                            ny = pt_y + ((rise > 0) ? 1 : -1);
                            if (ny == far_y)
                                p.last = 1'b1;
                            else
                            begin
                                e = e + ((rise > 0) ? -run : run);
                                if ((e < 0 && rise > 0) || (e > 0 && rise < 0))
                                begin
                                    pt_x = pt_x + 1;
                                    e = e + rise;
                                end
                            end
                            pt_y = ny;
                        end
                    endcase
                    err_acc = e;
                    if (p.last)
                        line_phase = PH_IDLE;
                end
                default:
                begin
                end
            endcase
        end
        return p;
    endfunction

    function automatic int rand_coord();
        return int'($urandom_range(0, 4095)) - 2048;
    endfunction

    function automatic int offset_end(int base, int off);
        int v;
        v = base + off;
        if (v > 2047 || v < -2048)
            v = base - off;
        return v;
    endfunction

    task automatic send_beat(input logic kind, input int xs, input int ys, input int xe,
                             input int ye);
        int        gap;
        line_req_t b;
        gap = steady ? 0 : $urandom_range(0, 17);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        b.kind = kind;
        b.xs = xs[CW-1:0];
        b.ys = ys[CW-1:0];
        b.xe = xe[CW-1:0];
        b.ye = ye[CW-1:0];
        req_ch.valid <= 1'b1;
        req_ch.kind <= b.kind;
        req_ch.x_start <= b.xs;
        req_ch.y_start <= b.ys;
        req_ch.x_end <= b.xe;
        req_ch.y_end <= b.ye;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        pixel_expect.push_back(next_pixel(b));
        beats_sent++;
    endtask

    task automatic send_step();
        send_beat(KIND_STEP, rand_coord(), rand_coord(), rand_coord(), rand_coord());
    endtask

    task automatic draw_line(input int xs, input int ys, input int xe, input int ye,
                             input int max_steps);
        int n;
        send_beat(KIND_LOAD, xs, ys, xe, ye);
        n = 0;
        while (line_phase != PH_IDLE && n < max_steps)
        begin
            send_step();
            n++;
        end
        lines_drawn++;
    endtask

    task automatic test_empty_step();
        steady = 1'b0;
        send_step();
    endtask

    task automatic test_single_point();
        steady = 1'b1;
        draw_line(5, -3, 5, -3, 100);
        send_step();
    endtask

    task automatic test_axis_line();
        steady = 1'b0;
        draw_line(2, 7, 0, 7, 100);
    endtask

    task automatic test_shallow_line();
        steady = 1'b0;
        draw_line(3, 0, 0, -2, 100);
    endtask

    task automatic test_steep_line();
        steady = 1'b1;
        draw_line(0, 0, 1, -3, 100);
    endtask

    task automatic test_abandoned_extremes();
        steady = 1'b0;
        draw_line(-2048, 2047, 2047, -2048, 3);
        draw_line(2047, -2048, -2048, 2047, 2);
    endtask

    task automatic test_random_lines();
        int stop_at;
        int pick;
        int span;
        int xs;
        int ys;
        int xe;
        int ye;
        int ox;
        int oy;
        int max_steps;
        stop_at = beats_sent + RANDOM_BEATS;
        while (beats_sent < stop_at)
        begin
            steady = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 9);
            span = ($urandom_range(0, 9) == 0) ? 60 : 12;
            xs = rand_coord();
            ys = rand_coord();
            ox = $urandom_range(1, span);
            oy = $urandom_range(0, ox);
            if ($urandom_range(0, 1))
                ox = -ox;
            if ($urandom_range(0, 1))
                oy = -oy;
            max_steps = 100000;
            case (pick)
                0:
                begin
                    xe = xs;
                    ye = offset_end(ys, $urandom_range(0, span) - span / 2);
                end
                1:
                begin
                    xe = offset_end(xs, $urandom_range(0, span) - span / 2);
                    ye = ys;
                end
                2, 3, 4:
                begin
                    xe = offset_end(xs, ox);
                    ye = offset_end(ys, oy);
                end
                5, 6:
                begin
                    xe = offset_end(xs, oy);
                    ye = offset_end(ys, ox);
                end
                7:
                begin
                    xe = offset_end(xs, ox);
                    ye = offset_end(ys, ($urandom_range(0, 1)) ? ox : -ox);
                end
                8:
                begin
                    xe = rand_coord();
                    ye = rand_coord();
                    max_steps = $urandom_range(0, 8);
                end
                default:
                begin
                    xe = offset_end(xs, ox);
                    ye = offset_end(ys, oy);
                    max_steps = $urandom_range(0, 10);
                end
            endcase
            draw_line(xs, ys, xe, ye, max_steps);
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 2)) send_step();
        end
    endtask

    initial
    begin
        pixel_t exp_px;
        int     stall;
        rsp_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = steady ? 0 : $urandom_range(0, 17);
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (rsp_ch.valid !== 1'b1);
            if (pixel_expect.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected pixel beat: valid=%0b x=%0d y=%0d last=%0b",
                             $realtime, rsp_ch.pixel_valid, $signed(rsp_ch.pixel_x),
                             $signed(rsp_ch.pixel_y), rsp_ch.last);
            end
            else
            begin
                exp_px = pixel_expect.pop_front();
                pixels_checked++;
                if (rsp_ch.pixel_valid !== exp_px.pixel_valid || rsp_ch.pixel_x !== exp_px.px ||
                    rsp_ch.pixel_y !== exp_px.py || rsp_ch.last !== exp_px.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: expected %0b/%0d/%0d/%0b, got %0b/%0d/%0d/%0b",
                                 $realtime, exp_px.pixel_valid, $signed(exp_px.px),
                                 $signed(exp_px.py), exp_px.last, rsp_ch.pixel_valid,
                                 $signed(rsp_ch.pixel_x), $signed(rsp_ch.pixel_y), rsp_ch.last);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n !== 1'b1 || (req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
            (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Timeout after %0d cycles with no beat moving.", quiet_cycles);
            $display("CHECKS FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        line_phase = PH_IDLE;
        line_mode = MODE_Y;
        pt_x = 0;
        pt_y = 0;
        far_x = 0;
        far_y = 0;
        axis_stop = 0;
        err_acc = 0;
        run2 = 0;
        rise2 = 0;
        steady = 1'b0;
        rst_n <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.kind <= KIND_STEP;
        req_ch.x_start <= '0;
        req_ch.y_start <= '0;
        req_ch.x_end <= '0;
        req_ch.y_end <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_step();
        test_single_point();
        test_axis_line();
        test_shallow_line();
        test_steep_line();
        test_abandoned_extremes();
        test_random_lines();
        req_ch.valid <= 1'b0;
        steady = 1'b0;
        while (pixel_expect.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d request beats over %0d lines (axis, shallow, steep, abandoned).",
                 beats_sent, lines_drawn);
        $display("Checked %0d pixel beats, %0d mismatches.", pixels_checked, mismatches);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
